FILE: sv/apt_pkg.sv
// Shared constants and types for the aging peer table.
// No dependencies; imported by aging_peer_table_unit.
`default_nettype none

package apt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 8;
	localparam int unsigned ADDR_W            = 32;
	localparam int unsigned TIME_W            = 32;
	localparam int unsigned KIND_W            = 2;
	localparam int unsigned SLOT_W            = 3;
	localparam int unsigned IN_DATA_W         = 64;
	localparam int unsigned OUT_DATA_W        = 40;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t EV_REFRESH = 2'd0;
	localparam kind_t EV_ADDED   = 2'd1;
	localparam kind_t EV_FULL    = 2'd2;
	localparam kind_t EV_REMOVED = 2'd3;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] addr;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/aging_peer_table_unit.sv
// Aging peer table: address learning table with per-entry last-seen times.
// Depends on apt_pkg for constants, event codes and the result type.
//
// Usage: each item on s_axis is one poll. tuser carries announce_valid, tdata
// carries peer_addr and now_time. An announcement of a non-zero address
// refreshes a matching entry, else fills the first free slot, else reports the
// table as full. Then the lowest occupied entry older than timeout_ticks is
// cleared and reported. Each poll gives zero, one or two items on m_axis; tlast
// marks the final one. timeout_ticks is written through cfg_valid/cfg_data;
// cfg_ready is always high.
// Timing: one shared subtractor walks the table through a registered-read
// memory, one entry a cycle. The lookup pass runs only for an announcement
// of a non-zero address and is followed by a write step; the aging pass
// stops at the first removal; the output step hands the results to the
// output register one by one. s_axis_tready is high only between polls.
// While m_axis is stalled the held result stays put and the sequencer
// waits before loading the next. Reset empties the table at once through
// the occupancy flags and sets timeout_ticks to 10000.
`default_nettype none

module aging_peer_table_unit #(
	parameter int unsigned TABLE_ENTRIES = apt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [apt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // peer_addr, now_time
	input  wire  [0:0]                       s_axis_tuser,  // announce_valid
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [apt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // slot_index, event_addr, pad
	output logic [apt_pkg::KIND_W-1:0]       m_axis_tuser,  // event_kind
	output logic                             m_axis_tlast,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [apt_pkg::TIME_W-1:0]       cfg_data
);
	import apt_pkg::*;

	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned PW = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_ANN  = 3'd2;
	localparam logic [2:0] ST_AGE  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [ADDR_W-1:0] addr_mem [0:TABLE_ENTRIES-1];
	logic [TIME_W-1:0] seen_mem [0:TABLE_ENTRIES-1];

	logic [2:0]               state_q;
	logic [PW-1:0]            ptr_q;
	logic                     chk_s1;
	logic                     vld_s1;
	logic [IW-1:0]            idx_s1;
	logic [ADDR_W-1:0]        rd_addr_s1;
	logic [TIME_W-1:0]        rd_seen_s1;
	logic [TABLE_ENTRIES-1:0] occ_q;
	logic [TIME_W-1:0]        timeout_q;
	logic                     hit_found_q;
	logic                     emp_found_q;
	logic [IW-1:0]            hit_idx_q;
	logic [IW-1:0]            emp_idx_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [TIME_W-1:0]        now_q;
	logic                     pend_q;
	logic                     rem_q;
	result_t                  pend_res_q;
	result_t                  rem_res_q;
	result_t                  out_res_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	logic              in_acc;
	logic              ann_in;
	logic              scanning;
	logic              issue;
	logic [IW-1:0]     rd_idx;
	logic              last_chk;
	logic [ADDR_W-1:0] op_a;
	logic [ADDR_W-1:0] op_b;
	logic [ADDR_W-1:0] diff;
	logic              hit;
	logic              timed;
	logic              wr_en;
	logic [IW-1:0]     wr_idx;
	logic              out_free;
	logic              load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign ann_in        = s_axis_tuser[0] && (s_axis_tdata[ADDR_W-1:0] != '0);
	assign cfg_ready     = 1'b1;

	assign scanning = (state_q == ST_LOOK) || (state_q == ST_AGE);
	assign issue    = scanning && (ptr_q < PW'(TABLE_ENTRIES)) && !timed;
	assign rd_idx   = ptr_q[IW-1:0];
	assign last_chk = chk_s1 && (idx_s1 == IW'(TABLE_ENTRIES - 1));

	// shared subtractor: equality for lookup, age for expiry
	assign op_a  = (state_q == ST_LOOK) ? addr_q : now_q;
	assign op_b  = (state_q == ST_LOOK) ? rd_addr_s1 : rd_seen_s1;
	assign diff  = op_a - op_b;
	assign hit   = chk_s1 && vld_s1 && (diff == '0);
	assign timed = (state_q == ST_AGE) && chk_s1 && vld_s1 && (diff > timeout_q);

	assign wr_en  = (state_q == ST_ANN) && (hit_found_q || emp_found_q);
	assign wr_idx = hit_found_q ? hit_idx_q : emp_idx_q;

	assign out_free = !out_valid_q || m_axis_tready;
	assign load     = (state_q == ST_OUT) && out_free && (pend_q || rem_q);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - ADDR_W - SLOT_W){1'b0}},
		out_res_q.addr, out_res_q.slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			chk_s1      <= 1'b0;
			vld_s1      <= 1'b0;
			occ_q       <= '0;
			timeout_q   <= TIMEOUT_RESET;
			hit_found_q <= 1'b0;
			emp_found_q <= 1'b0;
			pend_q      <= 1'b0;
			rem_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			chk_s1 <= issue;
			vld_s1 <= occ_q[rd_idx];
			if (issue) begin
				ptr_q <= ptr_q + PW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ptr_q       <= '0;
						hit_found_q <= 1'b0;
						emp_found_q <= 1'b0;
						pend_q      <= 1'b0;
						rem_q       <= 1'b0;
						state_q     <= ann_in ? ST_LOOK : ST_AGE;
					end
				end
				ST_LOOK: begin
					if (hit) begin
						hit_found_q <= 1'b1;
					end
					if (chk_s1 && !vld_s1) begin
						emp_found_q <= 1'b1;
					end
					if (last_chk) begin
						state_q <= ST_ANN;
					end
				end
				ST_ANN: begin
					if (!hit_found_q && emp_found_q) begin
						occ_q[emp_idx_q] <= 1'b1;
					end
					pend_q  <= 1'b1;
					ptr_q   <= '0;
					state_q <= ST_AGE;
				end
				ST_AGE: begin
					if (timed) begin
						occ_q[idx_s1] <= 1'b0;
						rem_q         <= 1'b1;
						state_q       <= ST_OUT;
					end else if (last_chk) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (pend_q) begin
						if (out_free) begin
							pend_q <= 1'b0;
							if (!rem_q) begin
								state_q <= ST_IDLE;
							end
						end
					end else if (rem_q) begin
						if (out_free) begin
							rem_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// table memory: registered read, single write port
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_addr_s1 <= addr_mem[rd_idx];
			rd_seen_s1 <= seen_mem[rd_idx];
			idx_s1     <= rd_idx;
		end
		if (wr_en) begin
			addr_mem[wr_idx] <= addr_q;
			seen_mem[wr_idx] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= s_axis_tdata[ADDR_W-1:0];
			now_q  <= s_axis_tdata[ADDR_W +: TIME_W];
		end
		if ((state_q == ST_LOOK) && hit && !hit_found_q) begin
			hit_idx_q <= idx_s1;
		end
		if ((state_q == ST_LOOK) && chk_s1 && !vld_s1 && !emp_found_q) begin
			emp_idx_q <= idx_s1;
		end
		if (state_q == ST_ANN) begin
			pend_res_q.addr <= addr_q;
			if (hit_found_q) begin
				pend_res_q.kind <= EV_REFRESH;
				pend_res_q.slot <= SLOT_W'(hit_idx_q);
			end else if (emp_found_q) begin
				pend_res_q.kind <= EV_ADDED;
				pend_res_q.slot <= SLOT_W'(emp_idx_q);
			end else begin
				pend_res_q.kind <= EV_FULL;
				pend_res_q.slot <= '0;
			end
		end
		if (timed) begin
			rem_res_q.kind <= EV_REMOVED;
			rem_res_q.slot <= SLOT_W'(idx_s1);
			rem_res_q.addr <= rd_addr_s1;
		end
		if (load) begin
			if (pend_q) begin
				out_res_q  <= pend_res_q;
				out_last_q <= !rem_q;
			end else begin
				out_res_q  <= rem_res_q;
				out_last_q <= 1'b1;
			end
		end
	end

	a_occ_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_ANN || state_q == ST_AGE) |=> (occ_q == $past(occ_q)))
		else $error("occupancy changed outside the update and aging steps");

	a_one_removal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AGE) |=> ($countones($past(occ_q) & ~occ_q) <= 1))
		else $error("more than one entry removed in one step");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!pend_q && !rem_q))
		else $error("results left pending while idle");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result loaded outside the output step");

	a_add_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ANN && !hit_found_q && emp_found_q) |-> !occ_q[emp_idx_q])
		else $error("new address placed in an occupied slot");

endmodule

`default_nettype wire

FILE: tb/sv/apt_checker.sv
// Checker for the aging peer table: watches the poll, result and timeout channels.
// Keeps its own copy of the table and compares every result item with its prediction.
// Depends on apt_pkg for widths, event codes and the timeout reset value.
`default_nettype none

module apt_checker #(
	parameter int unsigned TABLE_ENTRIES = apt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	input  wire                              s_axis_tready,
	input  wire  [apt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // peer_addr, now_time
	input  wire  [0:0]                       s_axis_tuser,  // announce_valid
	input  wire                              m_axis_tvalid,
	input  wire                              m_axis_tready,
	input  wire  [apt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // slot_index, event_addr, pad
	input  wire  [apt_pkg::KIND_W-1:0]       m_axis_tuser,  // event_kind
	input  wire                              m_axis_tlast,
	input  wire                              cfg_valid,
	input  wire                              cfg_ready,
	input  wire  [apt_pkg::TIME_W-1:0]       cfg_data,
	output int                               fail_count,
	output int                               awaited_count,
	output int                               polls_seen,
	output int                               events_seen
);
	import apt_pkg::*;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} peer_event_t;

	logic [ADDR_W-1:0] peer_addr_tab [TABLE_ENTRIES];
	logic [TIME_W-1:0] peer_seen_tab [TABLE_ENTRIES];
	logic [TIME_W-1:0] timeout_q;
	peer_event_t       awaited_events [$];

	task automatic predict_poll(input logic announce, input logic [ADDR_W-1:0] addr,
			input logic [TIME_W-1:0] now);
		int          hit;
		int          free;
		int          base;
		logic [TIME_W-1:0] age;
		peer_event_t ev;
		hit = -1;
		free = -1;
		base = awaited_events.size();
		if (announce && addr != '0) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (hit < 0 && peer_addr_tab[i] == addr)
					hit = i;
				if (free < 0 && peer_addr_tab[i] == '0)
					free = i;
			end
			if (hit >= 0) begin
				peer_seen_tab[hit] = now;
				awaited_events.push_back('{EV_REFRESH, SLOT_W'(hit), addr, 1'b0});
			end else if (free >= 0) begin
				peer_addr_tab[free] = addr;
				peer_seen_tab[free] = now;
				awaited_events.push_back('{EV_ADDED, SLOT_W'(free), addr, 1'b0});
			end else begin
				awaited_events.push_back('{EV_FULL, '0, addr, 1'b0});
			end
		end
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			age = now - peer_seen_tab[i];
			if (peer_addr_tab[i] != '0 && age > timeout_q) begin
				awaited_events.push_back('{EV_REMOVED, SLOT_W'(i), peer_addr_tab[i], 1'b0});
				peer_addr_tab[i] = '0;
				peer_seen_tab[i] = '0;
				break;
			end
		end
		if (awaited_events.size() > base) begin
			ev = awaited_events.pop_back();
			ev.last = 1'b1;
			awaited_events.push_back(ev);
		end
	endtask

	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		peer_event_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				peer_addr_tab[i] = '0;
				peer_seen_tab[i] = '0;
			end
			timeout_q = TIMEOUT_RESET;
			awaited_events.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				timeout_q = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				polls_seen++;
				predict_poll(s_axis_tuser[0], s_axis_tdata[ADDR_W-1:0],
					s_axis_tdata[ADDR_W +: TIME_W]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				events_seen++;
				if (awaited_events.size() == 0) begin
					$error("result item with none awaited: kind %0d slot %0d addr 0x%0h",
						m_axis_tuser, m_axis_tdata[SLOT_W-1:0],
						m_axis_tdata[SLOT_W +: ADDR_W]);
					fail_count++;
				end else begin
					want = awaited_events.pop_front();
					check_field("event_kind", ADDR_W'(want.kind), ADDR_W'(m_axis_tuser));
					check_field("slot_index", ADDR_W'(want.slot),
						ADDR_W'(m_axis_tdata[SLOT_W-1:0]));
					check_field("event_addr", want.addr, m_axis_tdata[SLOT_W +: ADDR_W]);
					check_field("last_of_run", ADDR_W'(want.last), ADDR_W'(m_axis_tlast));
					check_field("pad", '0,
						ADDR_W'(m_axis_tdata[OUT_DATA_W-1:SLOT_W+ADDR_W]));
				end
			end
		end
		awaited_count = awaited_events.size();
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Top of the aging peer table testbench: clock, reset, poll and timeout stimulus.
// Instantiates aging_peer_table_unit and apt_checker side by side; uses apt_pkg.
`default_nettype none

module tb_top;
	import apt_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int PHASE_POLLS  = 230;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic [0:0]              s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic [KIND_W-1:0]       m_axis_tuser;
	logic                    m_axis_tlast;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [TIME_W-1:0]       cfg_data = '0;

	int fail_count;
	int awaited_count;
	int polls_seen;
	int events_seen;
	int cycle_count = 0;
	int timeout_writes = 0;
	bit calm = 1'b0;

	aging_peer_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	apt_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.awaited_count (awaited_count),
		.polls_seen    (polls_seen),
		.events_seen   (events_seen)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_poll(input logic announce, input logic [ADDR_W-1:0] addr,
			input logic [TIME_W-1:0] now);
		while (!calm && $urandom_range(0, 99) < 37) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= announce;
		s_axis_tdata <= {now, addr};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	// hold off until every awaited item is in and the block has gone quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIME_W-1:0] ticks);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		timeout_writes++;
	endtask

	initial begin
		logic [TIME_W-1:0] timeout_plan [6];
		logic [ADDR_W-1:0] pool [12];
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] span;
		logic [ADDR_W-1:0] addr;
		int                roll;
		timeout_plan = '{32'd0, 32'd1, 32'd300, 32'hFFFF_FFFF, 32'd40,
			TIME_W'($urandom_range(2, 5000))};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timeout of 10000 ticks
		send_poll(1'b1, 32'hFFFF_FFFF, 32'd0);
		send_poll(1'b1, 32'h0000_0000, 32'd5);
		send_poll(1'b0, 32'h1234_5678, 32'd10);
		send_poll(1'b1, 32'hFFFF_FFFF, 32'd20);
		send_poll(1'b1, 32'h0000_0001, 32'd30);
		send_poll(1'b1, 32'h8000_0000, 32'd40);
		send_poll(1'b1, 32'h5555_5555, 32'd50);
		send_poll(1'b1, 32'hAAAA_AAAA, 32'd60);
		send_poll(1'b1, 32'h0000_0002, 32'd70);
		send_poll(1'b1, 32'h0000_0003, 32'd80);
		send_poll(1'b1, 32'h0000_0004, 32'd90);
		send_poll(1'b1, 32'hDEAD_BEEF, 32'd100);
		send_poll(1'b0, 32'h0000_0000, 32'd10020);
		send_poll(1'b0, 32'h0000_0000, 32'd10021);
		send_poll(1'b1, 32'hDEAD_BEEF, 32'd10022);
		send_poll(1'b1, 32'h0000_0001, 32'hFFFF_FFFF);
		send_poll(1'b1, 32'h0000_0012, 32'h0000_0005);
		send_poll(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
		settle();
		write_timeout(32'd0);
		send_poll(1'b1, 32'h0000_0012, 32'h0000_0005);
		send_poll(1'b0, 32'h0000_0000, 32'h0000_0005);
		send_poll(1'b0, 32'h0000_0000, 32'h0000_0006);
		send_poll(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
		now = 32'hFFFF_FF00;

		for (int p = 0; p < 6; p++) begin
			settle();
			write_timeout(timeout_plan[p]);
			calm = (p == 2);
			foreach (pool[i]) begin
				pool[i] = $urandom();
				if (pool[i] == '0)
					pool[i] = 32'h1;
			end
			if (timeout_plan[p] == 32'hFFFF_FFFF)
				span = 32'd1000;
			else
				span = (timeout_plan[p] / 4 + 2 > 1000) ? 32'd1000 : timeout_plan[p] / 4 + 2;
			repeat (PHASE_POLLS) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					now = $urandom();
				else if (roll < 5)
					now = now - TIME_W'($urandom_range(1, 50));
				else
					now = now + TIME_W'($urandom_range(0, span));
				roll = $urandom_range(0, 99);
				if (roll < 80)
					addr = pool[$urandom_range(0, 11)];
				else if (roll < 88)
					addr = '0;
				else
					addr = $urandom();
				send_poll($urandom_range(0, 99) < 75, addr, now);
			end
		end
		calm = 1'b0;

		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d polls giving %0d table events across %0d timeout settings,",
			polls_seen, events_seen, timeout_writes + 1);
		$display("including zero, one and the full 32-bit timeout and time wrap-around.");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
